[src/pcir_pkg.sv]
// ----------------------------------------------------------------------------
// pcir_pkg
// Shared widths, transaction side-band types and fixed-point helpers for the
// particle contact impulse resolver.
// ----------------------------------------------------------------------------
package pcir_pkg;

  localparam int CW     = 21;          // vector component width
  localparam int FB     = 11;          // fraction bits of a component
  localparam int VW     = 3 * CW;      // packed vector width
  localparam int IM_W   = 16;          // inverse mass width
  localparam int RS_W   = 16;          // restitution width
  localparam int TS_W   = 16;          // time step width
  localparam int PEN_W  = CW;          // penetration width
  localparam int REL_W  = CW + 1;      // relative component
  localparam int PROD_W = REL_W + CW;  // one term of a dot product
  localparam int DOT_W  = PROD_W + 2;  // dot product
  localparam int SV_W   = DOT_W + 1;   // target velocity arithmetic
  localparam int MUL_W  = SV_W + RS_W + 1;
  localparam int DLT_W  = DOT_W;       // velocity change, non-negative whenever an impulse is applied
  localparam int D_W    = IM_W + 1;    // divisor: total inverse mass
  localparam int Q_W    = DLT_W;       // quotient bits, one per divider stage
  localparam int N_W    = Q_W + D_W;   // dividend
  localparam int PN_W   = PEN_W - 1 + IM_W;
  localparam int G_W    = Q_W - FB + 1;
  localparam int P_W    = PEN_W;
  localparam int PG_W   = CW + G_W + 1;
  localparam int PP_W   = CW + P_W + 1;
  localparam int NL     = 4;           // divider lanes

  // divider lane assignment
  localparam int LN_GA = 0;
  localparam int LN_GB = 1;
  localparam int LN_PA = 2;
  localparam int LN_PB = 3;

  localparam logic [TS_W-1:0] TS_RESET = TS_W'(1092);

  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  typedef struct packed {
    logic [VW-1:0] va;
    logic [VW-1:0] vb;
    logic [VW-1:0] nrm;
    logic          has_b;
    logic          imp;
    logic          mov;
  } side_t;

  typedef logic [NL-1:0][N_W-1:0] num_vec_t;
  typedef logic [NL-1:0][Q_W-1:0] q_vec_t;

  typedef struct packed {
    logic [D_W-1:0] rem;
    logic [Q_W-1:0] low;
  } div_st_t;

  function automatic logic signed [CW-1:0] comp(logic [VW-1:0] v, int unsigned k);
    return $signed(v[k*CW +: CW]);
  endfunction

  // shift right, round to nearest, ties away from zero
  function automatic logic signed [63:0] shr_rnd(logic signed [63:0] v, int unsigned n);
    logic signed [63:0] s;
    s = v + (64'sd1 <<< (n - 1));
    if (v[63]) begin
      s = s - 64'sd1;
    end
    return s >>> n;
  endfunction

  function automatic logic [CW-1:0] sat(logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end
    return r[CW-1:0];
  endfunction

  // one restoring division step
  function automatic div_st_t div_step(div_st_t st, logic [D_W-1:0] d);
    div_st_t    res;
    logic [D_W:0] t;
    logic       ge;
    t  = {st.rem, st.low[Q_W-1]};
    ge = (t >= {1'b0, d});
    res.rem = ge ? D_W'(t - {1'b0, d}) : t[D_W-1:0];
    res.low = {st.low[Q_W-2:0], ge};
    return res;
  endfunction

endpackage

[src/pcir_front.sv]
// ----------------------------------------------------------------------------
// pcir_front
// Dot products, target separating velocity and dividends for the divider.
// Eight register stages.
// ----------------------------------------------------------------------------
module pcir_front import pcir_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [VW-1:0]     vel_a_i,
  input  logic [VW-1:0]     vel_b_i,
  input  logic [VW-1:0]     acc_a_i,
  input  logic [VW-1:0]     acc_b_i,
  input  logic [VW-1:0]     normal_i,
  input  logic [IM_W-1:0]   inv_mass_a_i,
  input  logic [IM_W-1:0]   inv_mass_b_i,
  input  logic              has_b_i,
  input  logic [PEN_W-1:0]  penetration_i,
  input  logic [RS_W-1:0]   restitution_i,
  input  logic [TS_W-1:0]   time_step_i,
  output logic              valid_o,
  output logic [D_W-1:0]    d_o,
  output num_vec_t          num_o,
  output side_t             side_o
);

  typedef struct packed {
    side_t                    side;
    logic signed [DOT_W-1:0]  sv;
    logic [D_W-1:0]           tot;
    logic [PN_W-1:0]          pna;
    logic [PN_W-1:0]          pnb;
    logic [IM_W-1:0]          ima;
    logic [IM_W-1:0]          imb;
    logic [RS_W-1:0]          rest;
  } ctx_t;

  logic [8:1] vld_q;

  // stage 1
  logic signed [REL_W-1:0] relv_d [3], relv_q [3];
  logic signed [REL_W-1:0] rela_d [3], rela_q [3];
  side_t                   side1_d, side1_q;
  logic [IM_W-1:0]         ima1_q, imb1_q;
  logic [PEN_W-1:0]        pen1_q;
  logic [RS_W-1:0]         rest1_q;
  // stage 2
  logic signed [PROD_W-1:0] pv_d [3], pv_q [3];
  logic signed [PROD_W-1:0] pa_d [3], pa_q [3];
  ctx_t                     ctx2_d, ctx2_q;
  // stage 3
  logic signed [DOT_W-1:0]  ad3_d, ad3_q;
  ctx_t                     ctx3_d, ctx3_q;
  // stage 4
  logic signed [MUL_W-1:0]  m1_d, m1_q, m2_d, m2_q;
  ctx_t                     ctx4_q;
  // stage 5
  logic signed [SV_W-1:0]   nsv5_d, nsv5_q, acc5_d, acc5_q;
  ctx_t                     ctx5_q;
  // stage 6
  logic signed [MUL_W-1:0]  m3_d, m3_q;
  logic signed [SV_W-1:0]   nsv6_q;
  logic                     neg6_q;
  ctx_t                     ctx6_q;
  // stage 7
  logic [DLT_W-1:0]         dlt7_d, dlt7_q;
  ctx_t                     ctx7_q;
  // stage 8
  num_vec_t                 num8_d, num8_q;
  logic [D_W-1:0]           tot8_q;
  side_t                    side8_q;

  always_comb begin
    logic signed [REL_W-1:0] ca, cb;
    for (int k = 0; k < 3; k++) begin
      ca = REL_W'(comp(vel_a_i, k));
      cb = has_b_i ? REL_W'(comp(vel_b_i, k)) : '0;
      relv_d[k] = ca - cb;
      ca = REL_W'(comp(acc_a_i, k));
      cb = has_b_i ? REL_W'(comp(acc_b_i, k)) : '0;
      rela_d[k] = ca - cb;
    end
    side1_d.va    = vel_a_i;
    side1_d.vb    = has_b_i ? vel_b_i : '0;
    side1_d.nrm   = normal_i;
    side1_d.has_b = has_b_i;
    side1_d.imp   = 1'b0;
    side1_d.mov   = 1'b0;
  end

  always_comb begin
    logic pen_pos;
    for (int k = 0; k < 3; k++) begin
      pv_d[k] = relv_q[k] * comp(side1_q.nrm, k);
      pa_d[k] = rela_q[k] * comp(side1_q.nrm, k);
    end
    pen_pos       = !pen1_q[PEN_W-1] && (pen1_q != '0);
    ctx2_d.side   = side1_q;
    ctx2_d.sv     = '0;
    ctx2_d.tot    = D_W'(ima1_q) + D_W'(imb1_q);
    ctx2_d.pna    = '0;
    ctx2_d.pnb    = '0;
    if (pen_pos) begin
      ctx2_d.pna = pen1_q[PEN_W-2:0] * ima1_q;
      ctx2_d.pnb = pen1_q[PEN_W-2:0] * imb1_q;
    end
    ctx2_d.ima    = ima1_q;
    ctx2_d.imb    = imb1_q;
    ctx2_d.rest   = rest1_q;
    ctx2_d.side.mov = (ctx2_d.tot != '0) && pen_pos;
  end

  always_comb begin
    ctx3_d    = ctx2_q;
    ctx3_d.sv = DOT_W'(pv_q[0]) + DOT_W'(pv_q[1]) + DOT_W'(pv_q[2]);
    ad3_d     = DOT_W'(pa_q[0]) + DOT_W'(pa_q[1]) + DOT_W'(pa_q[2]);
    ctx3_d.side.imp = (ctx2_q.tot != '0) && (ctx3_d.sv <= 0);
  end

  always_comb begin
    logic signed [SV_W-1:0] neg_sv;
    neg_sv = -SV_W'(ctx3_q.sv);
    m1_d   = neg_sv * $signed({1'b0, ctx3_q.rest});
    m2_d   = SV_W'(ad3_q) * $signed({1'b0, time_step_i});
  end

  always_comb begin
    nsv5_d = SV_W'(shr_rnd(64'(m1_q), 15));
    acc5_d = SV_W'(shr_rnd(64'(m2_q), 16));
    m3_d   = acc5_q * $signed({1'b0, ctx5_q.rest});
  end

  // acceleration-only closing velocity is taken off the target, floor at zero
  always_comb begin
    logic signed [SV_W-1:0] adj, tgt, dl;
    adj = neg6_q ? SV_W'(shr_rnd(64'(m3_q), 15)) : '0;
    tgt = nsv6_q + adj;
    if (tgt < 0) begin
      tgt = '0;
    end
    dl     = tgt - SV_W'(ctx6_q.sv);
    dlt7_d = dl[DLT_W-1:0];
  end

  always_comb begin
    logic [DLT_W+IM_W-1:0] pga, pgb;
    logic [N_W-1:0]        half;
    pga  = dlt7_q * ctx7_q.ima;
    pgb  = dlt7_q * ctx7_q.imb;
    half = N_W'(ctx7_q.tot >> 1);
    num8_d[LN_GA] = N_W'(pga) + half;
    num8_d[LN_GB] = N_W'(pgb) + half;
    num8_d[LN_PA] = N_W'(ctx7_q.pna) + half;
    num8_d[LN_PB] = N_W'(ctx7_q.pnb) + half;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[7:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    relv_q  <= relv_d;
    rela_q  <= rela_d;
    side1_q <= side1_d;
    ima1_q  <= inv_mass_a_i;
    imb1_q  <= has_b_i ? inv_mass_b_i : '0;
    pen1_q  <= penetration_i;
    rest1_q <= restitution_i;
    pv_q    <= pv_d;
    pa_q    <= pa_d;
    ctx2_q  <= ctx2_d;
    ctx3_q  <= ctx3_d;
    ad3_q   <= ad3_d;
    m1_q    <= m1_d;
    m2_q    <= m2_d;
    ctx4_q  <= ctx3_q;
    nsv5_q  <= nsv5_d;
    acc5_q  <= acc5_d;
    ctx5_q  <= ctx4_q;
    m3_q    <= m3_d;
    nsv6_q  <= nsv5_q;
    neg6_q  <= acc5_q[SV_W-1];
    ctx6_q  <= ctx5_q;
    dlt7_q  <= dlt7_d;
    ctx7_q  <= ctx6_q;
    num8_q  <= num8_d;
    tot8_q  <= ctx7_q.tot;
    side8_q <= ctx7_q.side;
  end

  assign valid_o = vld_q[8];
  assign d_o     = tot8_q;
  assign num_o   = num8_q;
  assign side_o  = side8_q;

endmodule

[src/pcir_div_pipe.sv]
// ----------------------------------------------------------------------------
// pcir_div_pipe
// Four-lane restoring divider by the total inverse mass, one quotient bit
// per stage, side-band carried alongside.
// ----------------------------------------------------------------------------
module pcir_div_pipe import pcir_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [D_W-1:0] d_i,
  input  num_vec_t       num_i,
  input  side_t          side_i,
  output logic           valid_o,
  output q_vec_t         q_o,
  output side_t          side_o
);

  div_st_t        st_d [Q_W][NL];
  div_st_t        st_q [Q_W][NL];
  logic [D_W-1:0] d_q  [Q_W];
  side_t          side_q [Q_W];
  logic [Q_W-1:0] vld_q;

  always_comb begin
    div_st_t init;
    for (int l = 0; l < NL; l++) begin
      init.rem    = num_i[l][N_W-1:Q_W];
      init.low    = num_i[l][Q_W-1:0];
      st_d[0][l]  = div_step(init, d_i);
    end
    for (int s = 1; s < Q_W; s++) begin
      for (int l = 0; l < NL; l++) begin
        st_d[s][l] = div_step(st_q[s-1][l], d_q[s-1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Q_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    st_q      <= st_d;
    d_q[0]    <= d_i;
    side_q[0] <= side_i;
    for (int s = 1; s < Q_W; s++) begin
      d_q[s]    <= d_q[s-1];
      side_q[s] <= side_q[s-1];
    end
  end

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      q_o[l] = st_q[Q_W-1][l].low;
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

[src/pcir_back.sv]
// ----------------------------------------------------------------------------
// pcir_back
// Scales the normal by the shares, applies them and saturates. Three stages,
// the last being the result register.
// ----------------------------------------------------------------------------
module pcir_back import pcir_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  q_vec_t        q_i,
  input  side_t         side_i,
  output logic          done_o,
  output logic [VW-1:0] new_vel_a_o,
  output logic [VW-1:0] new_vel_b_o,
  output logic [VW-1:0] move_a_o,
  output logic [VW-1:0] move_b_o,
  output logic          impulse_applied_o,
  output logic          moved_o
);

  logic [2:1]              vld_q;
  logic [G_W-1:0]          ga_d, ga_q, gb_d, gb_q;
  logic [P_W-1:0]          pa_q, pb_q;
  side_t                   side1_q, side2_q;
  logic signed [PG_W-1:0]  pga_d [3], pga_q [3], pgb_d [3], pgb_q [3];
  logic signed [PP_W-1:0]  ppa_d [3], ppa_q [3], ppb_d [3], ppb_q [3];
  logic [VW-1:0]           nva_d, nvb_d, ma_d, mb_d;
  logic                    done_q, imp_q, mov_q;
  logic [VW-1:0]           nva_q, nvb_q, ma_q, mb_q;

  always_comb begin
    logic [Q_W:0] ta, tb;
    ta   = {1'b0, q_i[LN_GA]} + (Q_W+1)'(1 << (FB - 1));
    tb   = {1'b0, q_i[LN_GB]} + (Q_W+1)'(1 << (FB - 1));
    ga_d = G_W'(ta >> FB);
    gb_d = G_W'(tb >> FB);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pga_d[k] = comp(side1_q.nrm, k) * $signed({1'b0, ga_q});
      pgb_d[k] = comp(side1_q.nrm, k) * $signed({1'b0, gb_q});
      ppa_d[k] = comp(side1_q.nrm, k) * $signed({1'b0, pa_q});
      ppb_d[k] = comp(side1_q.nrm, k) * $signed({1'b0, pb_q});
    end
  end

  always_comb begin
    logic signed [CW-1:0] va, vb;
    for (int k = 0; k < 3; k++) begin
      va = comp(side2_q.va, k);
      vb = comp(side2_q.vb, k);
      nva_d[k*CW +: CW] = va;
      nvb_d[k*CW +: CW] = vb;
      ma_d[k*CW +: CW]  = '0;
      mb_d[k*CW +: CW]  = '0;
      if (side2_q.imp) begin
        nva_d[k*CW +: CW] = sat(64'(va) + shr_rnd(64'(pga_q[k]), FB));
        nvb_d[k*CW +: CW] = sat(64'(vb) - shr_rnd(64'(pgb_q[k]), FB));
      end
      if (side2_q.mov) begin
        ma_d[k*CW +: CW] = sat(shr_rnd(64'(ppa_q[k]), FB));
        mb_d[k*CW +: CW] = sat(-shr_rnd(64'(ppb_q[k]), FB));
      end
    end
    if (!side2_q.has_b) begin
      nvb_d = '0;
      mb_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
      imp_q  <= 1'b0;
      mov_q  <= 1'b0;
    end else begin
      vld_q  <= {vld_q[1], valid_i};
      done_q <= vld_q[2];
      imp_q  <= vld_q[2] && side2_q.imp;
      mov_q  <= vld_q[2] && side2_q.mov;
    end
  end

  always_ff @(posedge clk_i) begin
    ga_q    <= ga_d;
    gb_q    <= gb_d;
    pa_q    <= P_W'(q_i[LN_PA]);
    pb_q    <= P_W'(q_i[LN_PB]);
    side1_q <= side_i;
    pga_q   <= pga_d;
    pgb_q   <= pgb_d;
    ppa_q   <= ppa_d;
    ppb_q   <= ppb_d;
    side2_q <= side1_q;
    nva_q   <= nva_d;
    nvb_q   <= nvb_d;
    ma_q    <= ma_d;
    mb_q    <= mb_d;
  end

  assign done_o            = done_q;
  assign new_vel_a_o       = nva_q;
  assign new_vel_b_o       = nvb_q;
  assign move_a_o          = ma_q;
  assign move_b_o          = mb_q;
  assign impulse_applied_o = imp_q;
  assign moved_o           = mov_q;

endmodule

[src/particle_contact_impulse_resolver.sv]
// ----------------------------------------------------------------------------
// particle_contact_impulse_resolver
// Fixed-point contact resolution for one particle pair per transaction:
// restitution impulse plus interpenetration correction.
// ----------------------------------------------------------------------------
// Fully pipelined: a new contact may be started in every cycle and busy is
// never raised. Each transaction produces exactly one result, shown on the
// result ports for one cycle with done_o high, after passing 8 stages of dot
// products and target velocity, 45 stages of the bit-per-stage divider by the
// total inverse mass and 3 stages to apply and saturate. The receiver cannot
// stall, so results must be taken as they come.
// time_step_i is written with time_step_we_i and resets to 1092 (about
// 1/60 s in Q0.16); write it only while no transaction is in flight.
// ----------------------------------------------------------------------------
module particle_contact_impulse_resolver import pcir_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             time_step_we_i,
  input  logic [TS_W-1:0]  time_step_i,
  input  logic [VW-1:0]    vel_a_i,
  input  logic [VW-1:0]    vel_b_i,
  input  logic [VW-1:0]    acc_a_i,
  input  logic [VW-1:0]    acc_b_i,
  input  logic [VW-1:0]    normal_i,
  input  logic [IM_W-1:0]  inv_mass_a_i,
  input  logic [IM_W-1:0]  inv_mass_b_i,
  input  logic             has_b_i,
  input  logic [PEN_W-1:0] penetration_i,
  input  logic [RS_W-1:0]  restitution_i,
  output logic             done_o,
  output logic [VW-1:0]    new_vel_a_o,
  output logic [VW-1:0]    new_vel_b_o,
  output logic [VW-1:0]    move_a_o,
  output logic [VW-1:0]    move_b_o,
  output logic             impulse_applied_o,
  output logic             moved_o
);

  logic [TS_W-1:0] ts_q;

  logic            f_vld;
  logic [D_W-1:0]  f_d;
  num_vec_t        f_num;
  side_t           f_side;

  logic            q_vld;
  q_vec_t          q_val;
  side_t           q_side;

  // no back-pressure anywhere: every stage advances every cycle
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= TS_RESET;
    end else if (time_step_we_i) begin
      ts_q <= time_step_i;
    end
  end

  // separating velocity, target velocity and divider operands
  pcir_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (start),
    .vel_a_i       (vel_a_i),
    .vel_b_i       (vel_b_i),
    .acc_a_i       (acc_a_i),
    .acc_b_i       (acc_b_i),
    .normal_i      (normal_i),
    .inv_mass_a_i  (inv_mass_a_i),
    .inv_mass_b_i  (inv_mass_b_i),
    .has_b_i       (has_b_i),
    .penetration_i (penetration_i),
    .restitution_i (restitution_i),
    .time_step_i   (ts_q),
    .valid_o       (f_vld),
    .d_o           (f_d),
    .num_o         (f_num),
    .side_o        (f_side)
  );

  // impulse and correction shares, rounded, divided by total inverse mass
  pcir_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_vld),
    .d_i     (f_d),
    .num_i   (f_num),
    .side_i  (f_side),
    .valid_o (q_vld),
    .q_o     (q_val),
    .side_o  (q_side)
  );

  // apply along the normal, saturate, register results
  pcir_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (q_vld),
    .q_i               (q_val),
    .side_i            (q_side),
    .done_o            (done_o),
    .new_vel_a_o       (new_vel_a_o),
    .new_vel_b_o       (new_vel_b_o),
    .move_a_o          (move_a_o),
    .move_b_o          (move_b_o),
    .impulse_applied_o (impulse_applied_o),
    .moved_o           (moved_o)
  );

`ifndef ASSERT_OFF
  a_flags_strobed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (impulse_applied_o || moved_o) |-> done_o)
    else $error("result flag raised without a result strobe");

  a_move_b_needs_moved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (move_b_o != '0)) |-> moved_o)
    else $error("B displaced without correction");

  a_no_move_when_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !moved_o) |-> ((move_a_o == '0) && (move_b_o == '0)))
    else $error("displacement reported without correction");
`endif

endmodule

[tb/particle_contact_impulse_resolver_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_contact_impulse_resolver_check
// Watches the contact and result channels, predicts each result and compares.
// ----------------------------------------------------------------------------
module particle_contact_impulse_resolver_check import pcir_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             busy,
  input  logic             time_step_we_i,
  input  logic [TS_W-1:0]  time_step_i,
  input  logic [VW-1:0]    vel_a_i,
  input  logic [VW-1:0]    vel_b_i,
  input  logic [VW-1:0]    acc_a_i,
  input  logic [VW-1:0]    acc_b_i,
  input  logic [VW-1:0]    normal_i,
  input  logic [IM_W-1:0]  inv_mass_a_i,
  input  logic [IM_W-1:0]  inv_mass_b_i,
  input  logic             has_b_i,
  input  logic [PEN_W-1:0] penetration_i,
  input  logic [RS_W-1:0]  restitution_i,
  input  logic             done_o,
  input  logic [VW-1:0]    new_vel_a_o,
  input  logic [VW-1:0]    new_vel_b_o,
  input  logic [VW-1:0]    move_a_o,
  input  logic [VW-1:0]    move_b_o,
  input  logic             impulse_applied_o,
  input  logic             moved_o,
  output int               errors_o,
  output int               pending_o
);

  typedef struct {
    logic [VW-1:0] vel_a;
    logic [VW-1:0] vel_b;
    logic [VW-1:0] mv_a;
    logic [VW-1:0] mv_b;
    logic          imp;
    logic          mov;
  } contact_res_t;

  contact_res_t      awaited_q[$];
  logic [TS_W-1:0]   step_len;

  function automatic longint part(logic [VW-1:0] v, int k);
    return longint'($signed(v[k*CW +: CW]));
  endfunction

  // rounds to nearest, ties away from zero; den > 0
  function automatic longint rdiv(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic longint rshift(longint v, int n);
    return rdiv(v, longint'(1) << n);
  endfunction

  function automatic logic [VW-1:0] pack_vec(longint x, longint y, longint z);
    longint c[3];
    logic [VW-1:0] r;
    c[0] = x; c[1] = y; c[2] = z;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      if (c[k] > SAT_HI) c[k] = SAT_HI;
      if (c[k] < SAT_LO) c[k] = SAT_LO;
      r[k*CW +: CW] = c[k][CW-1:0];
    end
    return r;
  endfunction

  function automatic longint rel_dot(logic [VW-1:0] a, logic [VW-1:0] b, logic use_b,
                                     logic [VW-1:0] n);
    longint s;
    longint r;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      r = part(a, k);
      if (use_b) r -= part(b, k);
      s += r * part(n, k);
    end
    return s;
  endfunction

  function automatic contact_res_t resolve_contact();
    contact_res_t res;
    longint va[3], vb[3], ma[3], mb[3];
    longint im_a, im_b, total, pen, rest, sv, new_sv, acc_sv, delta, ga, gb, pa, pb, n;
    im_a  = inv_mass_a_i;
    im_b  = has_b_i ? longint'(inv_mass_b_i) : 0;
    total = im_a + im_b;
    pen   = longint'($signed(penetration_i));
    rest  = restitution_i;
    res.imp = 1'b0;
    res.mov = 1'b0;
    for (int k = 0; k < 3; k++) begin
      va[k] = part(vel_a_i, k);
      vb[k] = has_b_i ? part(vel_b_i, k) : 0;
      ma[k] = 0;
      mb[k] = 0;
    end
    if (total != 0) begin
      sv = rel_dot(vel_a_i, vel_b_i, has_b_i, normal_i);
      if (sv <= 0) begin
        new_sv = rshift(-sv * rest, 15);
        acc_sv = rshift(rel_dot(acc_a_i, acc_b_i, has_b_i, normal_i) * longint'(step_len), 16);
        if (acc_sv < 0) begin
          new_sv += rshift(acc_sv * rest, 15);
          if (new_sv < 0) new_sv = 0;
        end
        delta = new_sv - sv;
        ga = rshift(rdiv(delta * im_a, total), FB);
        gb = rshift(rdiv(delta * im_b, total), FB);
        for (int k = 0; k < 3; k++) begin
          n = part(normal_i, k);
          va[k] += rshift(n * ga, FB);
          if (has_b_i) vb[k] -= rshift(n * gb, FB);
        end
        res.imp = 1'b1;
      end
      if (pen > 0) begin
        pa = rdiv(pen * im_a, total);
        pb = rdiv(pen * im_b, total);
        for (int k = 0; k < 3; k++) begin
          n = part(normal_i, k);
          ma[k] = rshift(n * pa, FB);
          if (has_b_i) mb[k] = -rshift(n * pb, FB);
        end
        res.mov = 1'b1;
      end
    end
    res.vel_a = pack_vec(va[0], va[1], va[2]);
    res.vel_b = has_b_i ? pack_vec(vb[0], vb[1], vb[2]) : '0;
    res.mv_a  = pack_vec(ma[0], ma[1], ma[2]);
    res.mv_b  = has_b_i ? pack_vec(mb[0], mb[1], mb[2]) : '0;
    return res;
  endfunction

  task automatic note_mismatch(string what, logic [VW-1:0] exp_v, logic [VW-1:0] got_v);
    errors_o++;
    if (errors_o <= 10)
      $display("mismatch %s: expected %h, got %h", what, exp_v, got_v);
  endtask

  assign pending_o = awaited_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    contact_res_t exp_r;
    if (!rst_ni) begin
      step_len <= TS_RESET;
      awaited_q.delete();
      errors_o = 0;
    end else begin
      if (time_step_we_i) step_len <= time_step_i;
      if (start && !busy) awaited_q.push_back(resolve_contact());
      if (done_o) begin
        if (awaited_q.size() == 0) begin
          note_mismatch("unexpected result", '0, '0);
        end else begin
          exp_r = awaited_q.pop_front();
          if (new_vel_a_o !== exp_r.vel_a) note_mismatch("new_vel_a", exp_r.vel_a, new_vel_a_o);
          if (new_vel_b_o !== exp_r.vel_b) note_mismatch("new_vel_b", exp_r.vel_b, new_vel_b_o);
          if (move_a_o !== exp_r.mv_a) note_mismatch("move_a", exp_r.mv_a, move_a_o);
          if (move_b_o !== exp_r.mv_b) note_mismatch("move_b", exp_r.mv_b, move_b_o);
          if (impulse_applied_o !== exp_r.imp)
            note_mismatch("impulse_applied", VW'(exp_r.imp), VW'(impulse_applied_o));
          if (moved_o !== exp_r.mov) note_mismatch("moved", VW'(exp_r.mov), VW'(moved_o));
        end
      end
    end
  end

endmodule

[tb/particle_contact_impulse_resolver_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_contact_impulse_resolver_test
// Drives directed and random contacts through the resolver under several
// time steps and idle patterns; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module particle_contact_impulse_resolver_test;
  import pcir_pkg::*;

  localparam int STALL_LIMIT = 5000; // cycles with no transaction at all
  localparam int DRAIN       = 60;   // pipeline depth is 56
  localparam int CHUNK       = 238;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             time_step_we_i = 1'b0;
  logic [TS_W-1:0]  time_step_i = '0;
  logic [VW-1:0]    vel_a_i = '0, vel_b_i = '0, acc_a_i = '0, acc_b_i = '0, normal_i = '0;
  logic [IM_W-1:0]  inv_mass_a_i = '0, inv_mass_b_i = '0;
  logic             has_b_i = 1'b0;
  logic [PEN_W-1:0] penetration_i = '0;
  logic [RS_W-1:0]  restitution_i = '0;
  logic             done_o;
  logic [VW-1:0]    new_vel_a_o, new_vel_b_o, move_a_o, move_b_o;
  logic             impulse_applied_o, moved_o;
  int               errors, pending, quiet_cycles;
  int               idle_pct;

  particle_contact_impulse_resolver dut (.*);

  particle_contact_impulse_resolver_check checker_i (
    .*,
    .errors_o (errors),
    .pending_o(pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // watchdog: a long stretch with neither a contact taken nor a result out
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // vector builders: 0 raw bits, 1 small values, 2 corner values, 3 unit axis
  function automatic logic [VW-1:0] make_vec(int kind);
    logic [VW-1:0] v;
    logic [CW-1:0] c;
    int            ax;
    v  = VW'({$urandom, $urandom});
    ax = $urandom_range(0, 2);
    for (int k = 0; k < 3; k++) begin
      case (kind)
        1: c = CW'($signed($urandom_range(0, 16383)) - 8192);
        2: begin
          case ($urandom_range(0, 3))
            0: c = {1'b0, {(CW-1){1'b1}}};
            1: c = {1'b1, {(CW-1){1'b0}}};
            2: c = '0;
            default: c = {CW{1'b1}};
          endcase
        end
        3: c = (k == ax) ? ($urandom_range(0, 1) ? CW'(2048) : -CW'(2048))
                         : CW'($signed($urandom_range(0, 255)) - 128);
        default: c = v[k*CW +: CW];
      endcase
      if (kind != 0) v[k*CW +: CW] = c;
    end
    return v;
  endfunction

  task automatic send_contact(logic [VW-1:0] va, logic [VW-1:0] vb, logic [VW-1:0] aa,
                              logic [VW-1:0] ab, logic [VW-1:0] nrm, logic [IM_W-1:0] ima,
                              logic [IM_W-1:0] imb, logic hb, logic [PEN_W-1:0] pen,
                              logic [RS_W-1:0] rest);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    vel_a_i <= va; vel_b_i <= vb; acc_a_i <= aa; acc_b_i <= ab; normal_i <= nrm;
    inv_mass_a_i <= ima; inv_mass_b_i <= imb; has_b_i <= hb;
    penetration_i <= pen; restitution_i <= rest;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic send_random();
    int            shape;
    logic [IM_W-1:0] ima, imb;
    logic [RS_W-1:0] rest;
    logic [PEN_W-1:0] pen;
    shape = $urandom_range(0, 9);
    ima = IM_W'($urandom); imb = IM_W'($urandom);
    if ($urandom_range(0, 9) == 0) ima = '0;
    if ($urandom_range(0, 9) == 0) imb = '0;
    rest = ($urandom_range(0, 9) == 0) ? RS_W'($urandom) : RS_W'($urandom_range(0, 32768));
    pen  = ($urandom_range(0, 3) == 0) ? PEN_W'($urandom)
                                       : PEN_W'($signed($urandom_range(0, 8191)) - 2048);
    if (shape < 2) begin
      send_contact(make_vec(0), make_vec(0), make_vec(0), make_vec(0), make_vec(0),
                   ima, imb, 1'($urandom), PEN_W'($urandom), RS_W'($urandom));
    end else if (shape == 2) begin
      send_contact(make_vec(2), make_vec(2), make_vec(2), make_vec(2), make_vec(2),
                   ima, imb, 1'($urandom), pen, rest);
    end else begin
      // plausible contact: modest velocities, near-unit normal
      send_contact(make_vec(1), make_vec(1), make_vec(1), make_vec(1), make_vec(3),
                   ima, imb, 1'($urandom), pen, rest);
    end
  endtask

  task automatic settle_and_set_step(logic [TS_W-1:0] ts);
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    time_step_we_i <= 1'b1;
    time_step_i    <= ts;
    @(posedge clk_i);
    time_step_we_i <= 1'b0;
  endtask

  initial begin
    logic [VW-1:0] vmax, vmin, nx, ones;
    logic [TS_W-1:0] steps[6];
    vmax = {3{1'b0, {(CW-1){1'b1}}}};
    vmin = {3{1'b1, {(CW-1){1'b0}}}};
    ones = '1;
    nx   = VW'(2048);
    idle_pct = 14;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zeros, corners, each path, reset time step
    send_contact('0, '0, '0, '0, '0, 0, 0, 0, 0, 0);
    send_contact(vmax, vmin, vmax, vmin, vmax, '1, '1, 1, PEN_W'(1048575), '1);
    send_contact(vmin, vmax, vmin, vmax, vmin, '1, '1, 1, PEN_W'(-1048576), 16'd32768);
    send_contact(ones, ones, ones, ones, ones, '1, 0, 0, '1, '1);
    // zero total inverse mass: pass through
    send_contact(vmin, vmax, vmin, vmax, nx, 0, 0, 1, 21'd500, 16'd32768);
    send_contact(vmin, vmax, vmin, vmax, nx, 0, 16'd4096, 0, 21'd500, 16'd32768);
    // separating contact, with and without penetration
    send_contact(VW'(4096), '0, '0, '0, nx, 16'd4096, 16'd4096, 1, 21'd300, 16'd16384);
    send_contact(VW'(4096), '0, '0, '0, nx, 16'd4096, 0, 0, -21'd300, 16'd16384);
    // zero separating velocity: impulse path with zero impulse
    send_contact('0, '0, '0, '0, nx, 16'd4096, 16'd4096, 1, 0, 16'd16384);
    // closing contacts, restitution 0, 1.0, above 1.0
    send_contact(-VW'(4096) & {{42{1'b0}}, {CW{1'b1}}}, '0, '0, '0, nx,
                 16'd4096, 16'd8192, 1, 21'd100, 0);
    send_contact({{42{1'b0}}, -CW'(4096)}, {{42{1'b0}}, CW'(2048)}, '0, '0, nx,
                 16'd4096, 16'd8192, 1, 21'd100, 16'd32768);
    send_contact({{42{1'b0}}, -CW'(4096)}, '0, '0, '0, nx, 16'd1, 0, 0, 21'd1, 16'd65535);
    // acceleration-only closing velocity, the first large enough to clamp target at zero
    send_contact({{42{1'b0}}, -CW'(100)}, '0, {{42{1'b0}}, -CW'(1000000)}, '0, nx,
                 16'd4096, 16'd4096, 1, 21'd2048, 16'd32768);
    send_contact({{42{1'b0}}, -CW'(5000)}, '0, {{42{1'b0}}, -CW'(20000)}, '0, nx,
                 16'd4096, 0, 0, 21'd2048, 16'd16384);
    // B side acceleration opposite
    send_contact({{42{1'b0}}, -CW'(5000)}, '0, '0, {{42{1'b0}}, CW'(20000)}, nx,
                 16'd100, 16'd50000, 1, 21'd4096, 16'd20000);
    // penetration at smallest positive, zero
    send_contact(make_vec(1), make_vec(1), make_vec(1), make_vec(1), make_vec(3),
                 16'd3, 16'd7, 1, 21'd1, 16'd1);
    send_contact(make_vec(1), make_vec(1), make_vec(1), make_vec(1), make_vec(3),
                 16'd3, 16'd7, 1, 21'd0, 16'd1);

    // random phases, each under its own time step; extremes first
    steps[0] = '0;
    steps[1] = '1;
    steps[2] = TS_W'($urandom);
    steps[3] = TS_W'(1);
    steps[4] = TS_W'($urandom);
    steps[5] = TS_RESET;
    for (int ph = 0; ph < 6; ph++) begin
      settle_and_set_step(steps[ph]);
      idle_pct = (ph < 2) ? 14 : (ph < 4) ? 49 : 0;
      for (int i = 0; i < CHUNK; i++) begin
        // short stretch with no gaps even in idling phases
        if (ph < 4 && i == CHUNK / 2) idle_pct = 0;
        if (ph < 4 && i == CHUNK / 2 + 24) idle_pct = (ph < 2) ? 14 : 49;
        send_random();
      end
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
